/* hdl/rsi_pkg.sv */
// Shared types and constants for the ray-sphere intersection pipeline.
package rsi_pkg;

    localparam int Q_W    = 32;
    localparam int R2_W   = 31;
    localparam int IDX_W  = 3;
    localparam int B_W    = 67;
    localparam int ROOT_W = 66;
    localparam int DET_W  = 2 * ROOT_W;

    localparam logic [IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RADIUS2  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_FRONT    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_BACK     = 3'd5;

    typedef struct packed {
        logic [Q_W-1:0]  cx;
        logic [Q_W-1:0]  cy;
        logic [Q_W-1:0]  cz;
        logic [R2_W-1:0] r2;
    } t_sphere;

    typedef struct packed {
        logic           pos;
        logic [B_W-1:0] b;
        logic [Q_W-1:0] min_d;
        logic [Q_W-1:0] cur_d;
    } t_tag;

endpackage

/* hdl/rsi_front.sv */
// Front stages: offsets, dot products, wide squares and discriminant.
module rsi_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  logic [rsi_pkg::Q_W-1:0]        i_ox,
    input  logic [rsi_pkg::Q_W-1:0]        i_oy,
    input  logic [rsi_pkg::Q_W-1:0]        i_oz,
    input  logic [rsi_pkg::Q_W-1:0]        i_dx,
    input  logic [rsi_pkg::Q_W-1:0]        i_dy,
    input  logic [rsi_pkg::Q_W-1:0]        i_dz,
    input  logic [rsi_pkg::Q_W-1:0]        i_min,
    input  logic [rsi_pkg::Q_W-1:0]        i_cur,
    input  rsi_pkg::t_sphere               i_sph,
    output logic                           o_vld,
    output logic [rsi_pkg::DET_W-1:0]      o_det,
    output rsi_pkg::t_tag                  o_tag
);
    localparam int NS = 6;

    logic [NS-1:0] r_vld;
    logic [rsi_pkg::Q_W-1:0] r_min [NS];
    logic [rsi_pkg::Q_W-1:0] r_cur [NS];

    // S1
    logic signed [32:0] r_v [3];
    logic signed [31:0] r_d [3];
    // S2
    logic signed [64:0] r_pvd [3];
    logic [62:0]        r_pdd [3];
    logic [64:0]        r_pvv [3];
    // S3
    logic signed [66:0] r_b3;
    logic [64:0]        r_mag;
    logic [63:0]        r_dd;
    logic [65:0]        r_vv;
    // S4
    logic [66:0] r_b4;
    logic [63:0] r_pp_hh;
    logic [64:0] r_pp_hl;
    logic [65:0] r_pp_ll;
    logic [64:0] r_q_hh, r_q_hl, r_q_lh, r_q_ll;
    // S5
    logic [66:0]  r_b5;
    logic [129:0] r_bb;
    logic [130:0] r_ddvv;
    // S6
    logic [66:0]  r_b6;
    logic [131:0] r_det;
    logic         r_pos;

    logic [31:0] o_arr [3];
    logic [31:0] d_arr [3];
    logic [31:0] c_arr [3];
    logic signed [64:0] n_pvd [3];
    logic signed [63:0] n_pdd [3];
    logic signed [65:0] n_pvv [3];
    logic signed [66:0] n_vd;
    logic signed [131:0] n_det;

    assign o_arr = '{i_ox, i_oy, i_oz};
    assign d_arr = '{i_dx, i_dy, i_dz};
    assign c_arr = '{i_sph.cx, i_sph.cy, i_sph.cz};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pvd[i] = r_v[i] * r_d[i];
            n_pdd[i] = r_d[i] * r_d[i];
            n_pvv[i] = r_v[i] * r_v[i];
        end
        n_vd = {{2{r_pvd[0][64]}}, r_pvd[0]} + {{2{r_pvd[1][64]}}, r_pvd[1]}
             + {{2{r_pvd[2][64]}}, r_pvd[2]};
        n_det = $signed({2'b0, r_bb}) - $signed({1'b0, r_ddvv})
              + $signed({53'b0, i_sph.r2, 48'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_min[0] <= i_min;
        r_cur[0] <= i_cur;
        for (int s = 1; s < NS; s++) begin
            r_min[s] <= r_min[s-1];
            r_cur[s] <= r_cur[s-1];
        end
        for (int i = 0; i < 3; i++) begin
            r_v[i]   <= $signed({o_arr[i][31], o_arr[i]}) - $signed({c_arr[i][31], c_arr[i]});
            r_d[i]   <= $signed(d_arr[i]);
            r_pvd[i] <= n_pvd[i];
            r_pdd[i] <= n_pdd[i][62:0];
            r_pvv[i] <= n_pvv[i][64:0];
        end
        r_b3  <= -n_vd;
        r_mag <= n_vd[66] ? 65'(-n_vd) : n_vd[64:0];
        r_dd  <= {1'b0, r_pdd[0]} + {1'b0, r_pdd[1]} + {1'b0, r_pdd[2]};
        r_vv  <= {1'b0, r_pvv[0]} + {1'b0, r_pvv[1]} + {1'b0, r_pvv[2]};

        r_b4    <= r_b3;
        r_pp_hh <= r_mag[64:33] * r_mag[64:33];
        r_pp_hl <= r_mag[64:33] * r_mag[32:0];
        r_pp_ll <= r_mag[32:0] * r_mag[32:0];
        r_q_hh  <= r_dd[63:32] * r_vv[65:33];
        r_q_hl  <= r_dd[63:32] * r_vv[32:0];
        r_q_lh  <= r_dd[31:0] * r_vv[65:33];
        r_q_ll  <= r_dd[31:0] * r_vv[32:0];

        r_b5   <= r_b4;
        r_bb   <= {r_pp_hh, 66'b0} + {31'b0, r_pp_hl, 34'b0} + {64'b0, r_pp_ll};
        r_ddvv <= {1'b0, r_q_hh, 65'b0} + {34'b0, r_q_hl, 32'b0}
                + {33'b0, r_q_lh, 33'b0} + {66'b0, r_q_ll};

        r_b6  <= r_b5;
        r_det <= n_det;
        r_pos <= !n_det[131] && (n_det != '0);
    end

    assign o_vld       = r_vld[NS-1];
    assign o_det       = r_det;
    assign o_tag.pos   = r_pos;
    assign o_tag.b     = r_b6;
    assign o_tag.min_d = r_min[NS-1];
    assign o_tag.cur_d = r_cur[NS-1];

endmodule

/* hdl/rsi_sqrt.sv */
// Pipelined restoring integer square root, one root bit per stage.
module rsi_sqrt #(
    parameter int N  = 66,
    parameter int PW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [2*N-1:0]  i_rad,
    input  logic [PW-1:0]   i_pl,
    output logic            o_vld,
    output logic [N-1:0]    o_root,
    output logic [PW-1:0]   o_pl
);
    localparam int RW = N + 2;

    logic [N-1:0]   r_vld;
    logic [RW-1:0]  r_rem  [N];
    logic [N-1:0]   r_root [N];
    logic [2*N-1:0] r_rad  [N];
    logic [PW-1:0]  r_pl   [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-2:0], i_vld};
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [RW-1:0]  p_rem;
        logic [N-1:0]   p_root;
        logic [2*N-1:0] p_rad;
        logic [PW-1:0]  p_pl;
        logic [RW-1:0]  rem_in;
        logic [RW-1:0]  trial;
        logic           ge;

        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_pl   = i_pl;
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_rad  = r_rad[g-1];
            assign p_pl   = r_pl[g-1];
        end

        assign rem_in = {p_rem[RW-3:0], p_rad[2*N-1:2*N-2]};
        assign trial  = {p_root, 2'b01};
        assign ge     = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= ge ? rem_in - trial : rem_in;
            r_root[g] <= {p_root[N-2:0], ge};
            r_rad[g]  <= {p_rad[2*N-3:0], 2'b00};
            r_pl[g]   <= p_pl;
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_root = r_root[N-1];
    assign o_pl   = r_pl[N-1];

endmodule

/* hdl/ray_sphere_intersect.sv */
// Top level: configuration registers, pipeline and root selection.
// Tests one ray per clock against the configured sphere. A ray is taken whenever
// i_start is high (o_busy stays low) and its result appears as a one-cycle
// o_valid beat after 6 stages of products and discriminant, 66 stages of
// the square root (one root bit per stage), and one stage of root selection.
// Results cannot be held off. Configuration writes are always ready and should
// only be made with no rays in flight.
module ray_sphere_intersect (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [rsi_pkg::Q_W-1:0]       i_origin_x,
    input  logic [rsi_pkg::Q_W-1:0]       i_origin_y,
    input  logic [rsi_pkg::Q_W-1:0]       i_origin_z,
    input  logic [rsi_pkg::Q_W-1:0]       i_dir_x,
    input  logic [rsi_pkg::Q_W-1:0]       i_dir_y,
    input  logic [rsi_pkg::Q_W-1:0]       i_dir_z,
    input  logic [rsi_pkg::Q_W-1:0]       i_min_distance,
    input  logic [rsi_pkg::Q_W-1:0]       i_current_distance,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_inside_hit,
    output logic [rsi_pkg::Q_W-1:0]       o_new_distance,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rsi_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [rsi_pkg::Q_W-1:0]       i_cfg_data
);
    localparam int PW = $bits(rsi_pkg::t_tag);

    rsi_pkg::t_sphere r_sph;
    logic             r_front;
    logic             r_back;

    logic                       f_vld;
    logic [rsi_pkg::DET_W-1:0]  f_det;
    rsi_pkg::t_tag              f_tag;
    logic                       s_vld;
    logic [rsi_pkg::ROOT_W-1:0] s_root;
    logic [PW-1:0]              s_pl;
    rsi_pkg::t_tag              s_tag;

    logic signed [68:0] n_near, n_far, n_mind, n_curd;
    logic               n_front_ok, n_back_ok;

    logic                    r_valid;
    logic                    r_hit;
    logic                    r_inside;
    logic [rsi_pkg::Q_W-1:0] r_dist;
    logic [rsi_pkg::Q_W-1:0] r_min_q;
    logic [rsi_pkg::Q_W-1:0] r_cur_q;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sph   <= '{cx: '0, cy: '0, cz: '0, r2: 31'd65536};
            r_front <= 1'b1;
            r_back  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rsi_pkg::CFG_CENTER_X: r_sph.cx <= i_cfg_data;
                rsi_pkg::CFG_CENTER_Y: r_sph.cy <= i_cfg_data;
                rsi_pkg::CFG_CENTER_Z: r_sph.cz <= i_cfg_data;
                rsi_pkg::CFG_RADIUS2:  r_sph.r2 <= i_cfg_data[rsi_pkg::R2_W-1:0];
                rsi_pkg::CFG_FRONT:    r_front  <= i_cfg_data[0];
                rsi_pkg::CFG_BACK:     r_back   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_ox    (i_origin_x),
        .i_oy    (i_origin_y),
        .i_oz    (i_origin_z),
        .i_dx    (i_dir_x),
        .i_dy    (i_dir_y),
        .i_dz    (i_dir_z),
        .i_min   (i_min_distance),
        .i_cur   (i_current_distance),
        .i_sph   (r_sph),
        .o_vld   (f_vld),
        .o_det   (f_det),
        .o_tag   (f_tag)
    );

    rsi_sqrt #(
        .N  (rsi_pkg::ROOT_W),
        .PW (PW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_rad   (f_det),
        .i_pl    (f_tag),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_pl    (s_pl)
    );

    assign s_tag = rsi_pkg::t_tag'(s_pl);

    always_comb begin
        n_near = $signed({{2{s_tag.b[66]}}, s_tag.b}) - $signed({3'b0, s_root});
        n_far  = $signed({{2{s_tag.b[66]}}, s_tag.b}) + $signed({3'b0, s_root});
        n_mind = $signed({{21{s_tag.min_d[31]}}, s_tag.min_d, 16'b0});
        n_curd = $signed({{21{s_tag.cur_d[31]}}, s_tag.cur_d, 16'b0});
        n_front_ok = s_tag.pos && (n_mind < n_far) && r_front
                   && (n_near < n_curd) && (n_mind < n_near);
        n_back_ok  = s_tag.pos && (n_mind < n_far) && r_back && (n_far < n_curd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_q <= s_tag.min_d;
        r_cur_q <= s_tag.cur_d;
        if (n_front_ok) begin
            r_hit    <= 1'b1;
            r_inside <= 1'b0;
            r_dist   <= n_near[47:16];
        end else if (n_back_ok) begin
            r_hit    <= 1'b1;
            r_inside <= 1'b1;
            r_dist   <= n_far[47:16];
        end else begin
            r_hit    <= 1'b0;
            r_inside <= 1'b0;
            r_dist   <= s_tag.cur_d;
        end
    end

    assign o_valid        = r_valid;
    assign o_hit          = r_hit;
    assign o_inside_hit   = r_inside;
    assign o_new_distance = r_dist;

    a_inside_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_inside_hit |-> o_hit)
        else $error("inside hit without hit");

    a_miss_keeps_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_new_distance == r_cur_q)
        else $error("miss changed distance");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> ($signed(o_new_distance) < $signed(r_cur_q))
                          && ($signed(o_new_distance) >= $signed(r_min_q)))
        else $error("hit distance out of range");

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat after reset");

endmodule
